### rtl/css_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the cocktail shaker sorter.
package css_pkg;

    localparam int DEPTH = 64;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int KW    = 32;

    typedef logic signed [KW-1:0] key_t;
    typedef logic [AW-1:0]        addr_t;
    typedef logic [CW-1:0]        cnt_t;

    typedef enum logic [9:0] {
        ST_LOAD    = 10'b00_0000_0001,
        ST_D_PRIME = 10'b00_0000_0010,
        ST_D_FIRST = 10'b00_0000_0100,
        ST_D_STEP  = 10'b00_0000_1000,
        ST_D_END   = 10'b00_0001_0000,
        ST_U_PRIME = 10'b00_0010_0000,
        ST_U_FIRST = 10'b00_0100_0000,
        ST_U_STEP  = 10'b00_1000_0000,
        ST_U_END   = 10'b01_0000_0000,
        ST_OUT     = 10'b10_0000_0000
    } state_t;

endpackage

### rtl/css_ram.sv
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM with one write port and a registered read port.
module css_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/cocktail_shaker_sorter.sv
`timescale 1ns / 1ps
// Cocktail shaker sorter: key store, sort sequencer and result stream.
//
//   Channel | Handshake          | Payload
//   --------+--------------------+------------------------------------
//   in      | in_valid, in_stall | key, last
//   out     | out_valid, out_stall | sorted_key, final_res, dropped
//
// Keys load at one per cycle. After the transaction marked last, the sort runs
// out of the single key RAM: every compare-and-swap step is one RAM write and, but
// for the last step of a pass, one read, with the bubbling key held in a register.
// Results then leave one at a time, each read from the RAM into the output
// register; the next read waits until the current result is taken. No reset pass
// is needed, and a stall on the output simply holds the current result.
module cocktail_shaker_sorter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  css_pkg::key_t      key,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_stall,
    output css_pkg::key_t      sorted_key,
    output logic               final_res,
    output logic               dropped
);

    import css_pkg::*;

    state_t state_reg, state_next;
    cnt_t   count_reg, count_next;
    logic   overflow_reg, overflow_next;
    cnt_t   left_reg, left_next;
    cnt_t   right_reg, right_next;
    cnt_t   ls_reg, ls_next;
    cnt_t   j_reg, j_next;
    key_t   carry_reg, carry_next;
    cnt_t   idx_reg, idx_next;
    logic   pend_reg, pend_next;
    logic   pend_final_reg, pend_final_next;
    logic   out_valid_reg, out_valid_next;
    key_t   out_key_reg, out_key_next;
    logic   out_final_reg, out_final_next;
    logic   out_drop_reg, out_drop_next;

    logic   mem_we;
    addr_t  mem_waddr;
    key_t   mem_wdata;
    logic   mem_re;
    addr_t  mem_raddr;
    key_t   mem_rdata;

    logic   in_acc;
    logic   out_acc;
    cnt_t   n_load;
    cnt_t   jm1, jm2, jp1, lm1, lsp1, lsm1;

    css_ram #(
        .WIDTH (KW),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign in_stall   = (state_reg != ST_LOAD);
    assign in_acc     = in_valid && (state_reg == ST_LOAD);
    assign out_acc    = out_valid_reg && !out_stall;
    assign out_valid  = out_valid_reg;
    assign sorted_key = out_key_reg;
    assign final_res  = out_final_reg;
    assign dropped    = out_drop_reg;

    assign jm1  = j_reg - cnt_t'(1);
    assign jm2  = j_reg - cnt_t'(2);
    assign jp1  = j_reg + cnt_t'(1);
    assign lm1  = left_reg - cnt_t'(1);
    assign lsp1 = ls_reg + cnt_t'(1);
    assign lsm1 = ls_reg - cnt_t'(1);
    assign n_load = (count_reg < cnt_t'(DEPTH)) ? count_reg + cnt_t'(1) : count_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        overflow_next   = overflow_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        ls_next         = ls_reg;
        j_next          = j_reg;
        carry_next      = carry_reg;
        idx_next        = idx_reg;
        pend_next       = pend_reg;
        pend_final_next = pend_final_reg;
        out_valid_next  = out_valid_reg;
        out_key_next    = out_key_reg;
        out_final_next  = out_final_reg;
        out_drop_next   = out_drop_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = carry_reg;
        mem_re          = 1'b0;
        mem_raddr       = '0;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (count_reg < cnt_t'(DEPTH))
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = count_reg[AW-1:0];
                        mem_wdata  = key;
                        count_next = count_reg + cnt_t'(1);
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                    if (last)
                    begin
                        left_next  = cnt_t'(1);
                        right_next = n_load - cnt_t'(1);
                        ls_next    = n_load - cnt_t'(1);
                        idx_next   = '0;
                        state_next = (n_load >= cnt_t'(2)) ? ST_D_PRIME : ST_OUT;
                    end
                end
            end

            // Downward pass: the carried key moves towards the left bound.
            ST_D_PRIME:
            begin
                mem_re     = 1'b1;
                mem_raddr  = right_reg[AW-1:0];
                j_next     = right_reg;
                state_next = ST_D_FIRST;
            end

            ST_D_FIRST:
            begin
                carry_next = mem_rdata;
                mem_re     = 1'b1;
                mem_raddr  = jm1[AW-1:0];
                state_next = ST_D_STEP;
            end

            ST_D_STEP:
            begin
                mem_we    = 1'b1;
                mem_waddr = j_reg[AW-1:0];
                if (mem_rdata > carry_reg)
                begin
                    mem_wdata = mem_rdata;
                    ls_next   = j_reg;
                end
                else
                begin
                    mem_wdata  = carry_reg;
                    carry_next = mem_rdata;
                end
                if (j_reg == left_reg)
                begin
                    state_next = ST_D_END;
                end
                else
                begin
                    j_next    = jm1;
                    mem_re    = 1'b1;
                    mem_raddr = jm2[AW-1:0];
                end
            end

            ST_D_END:
            begin
                mem_we     = 1'b1;
                mem_waddr  = lm1[AW-1:0];
                mem_wdata  = carry_reg;
                left_next  = lsp1;
                state_next = (lsp1 <= right_reg) ? ST_U_PRIME : ST_OUT;
            end

            // Upward pass: the carried key moves towards the right bound.
            ST_U_PRIME:
            begin
                mem_re     = 1'b1;
                mem_raddr  = lm1[AW-1:0];
                j_next     = left_reg;
                state_next = ST_U_FIRST;
            end

            ST_U_FIRST:
            begin
                carry_next = mem_rdata;
                mem_re     = 1'b1;
                mem_raddr  = j_reg[AW-1:0];
                state_next = ST_U_STEP;
            end

            ST_U_STEP:
            begin
                mem_we    = 1'b1;
                mem_waddr = jm1[AW-1:0];
                if (carry_reg > mem_rdata)
                begin
                    mem_wdata = mem_rdata;
                    ls_next   = j_reg;
                end
                else
                begin
                    mem_wdata  = carry_reg;
                    carry_next = mem_rdata;
                end
                if (j_reg == right_reg)
                begin
                    state_next = ST_U_END;
                end
                else
                begin
                    j_next    = jp1;
                    mem_re    = 1'b1;
                    mem_raddr = jp1[AW-1:0];
                end
            end

            ST_U_END:
            begin
                mem_we     = 1'b1;
                mem_waddr  = right_reg[AW-1:0];
                mem_wdata  = carry_reg;
                right_next = lsm1;
                state_next = (left_reg <= lsm1) ? ST_D_PRIME : ST_OUT;
            end

            ST_OUT:
            begin
                if (out_acc)
                begin
                    out_valid_next = 1'b0;
                end
                if (pend_reg)
                begin
                    pend_next      = 1'b0;
                    out_valid_next = 1'b1;
                    out_key_next   = mem_rdata;
                    out_final_next = pend_final_reg;
                    out_drop_next  = pend_final_reg && overflow_reg;
                end
                else if ((idx_reg < count_reg) && (!out_valid_reg || out_acc))
                begin
                    mem_re          = 1'b1;
                    mem_raddr       = idx_reg[AW-1:0];
                    pend_next       = 1'b1;
                    pend_final_next = (idx_reg == count_reg - cnt_t'(1));
                    idx_next        = idx_reg + cnt_t'(1);
                end
                // Once the final transaction leaves, the block is ready for a new set.
                if (out_acc && out_final_reg)
                begin
                    state_next    = ST_LOAD;
                    count_next    = '0;
                    overflow_next = 1'b0;
                    left_next     = cnt_t'(1);
                    right_next    = '0;
                    ls_next       = '0;
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            count_reg      <= '0;
            overflow_reg   <= 1'b0;
            left_reg       <= cnt_t'(1);
            right_reg      <= '0;
            ls_reg         <= '0;
            j_reg          <= '0;
            idx_reg        <= '0;
            pend_reg       <= 1'b0;
            pend_final_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            overflow_reg   <= overflow_next;
            left_reg       <= left_next;
            right_reg      <= right_next;
            ls_reg         <= ls_next;
            j_reg          <= j_next;
            idx_reg        <= idx_next;
            pend_reg       <= pend_next;
            pend_final_reg <= pend_final_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        carry_reg     <= carry_next;
        out_key_reg   <= out_key_next;
        out_final_reg <= out_final_next;
        out_drop_reg  <= out_drop_next;
    end

endmodule

### rtl/css_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the cocktail shaker sorter, bound to the top level.
module css_assertions (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_stall,
    input  logic          last,
    input  logic          out_valid,
    input  logic          out_stall,
    input  css_pkg::key_t sorted_key,
    input  logic          final_res,
    input  logic          dropped
);

    // A stalled result must hold until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sorted_key))
        else $error("stalled result changed");

    // No input transaction is taken while results are being delivered.
    a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open during result delivery");

    // A drop is only reported on the final result.
    a_drop_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dropped |-> final_res)
        else $error("drop flag on a non-final result");

    // The transaction marked last closes the input for the sort.
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last |=> in_stall)
        else $error("input still open after last");

    // Taking the final result reopens the input.
    a_final_reopens: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && final_res |=> !in_stall && !out_valid)
        else $error("block not idle after final result");

endmodule

bind cocktail_shaker_sorter css_assertions u_css_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .last       (last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sorted_key (sorted_key),
    .final_res  (final_res),
    .dropped    (dropped)
);

### dv/css_checker.sv
`timescale 1ns / 1ps
// Checker for the cocktail shaker sorter: predicts each sorted run and compares every result.
module css_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_stall,
    input  css_pkg::key_t key,
    input  logic          last,
    input  logic          out_valid,
    input  logic          out_stall,
    input  css_pkg::key_t sorted_key,
    input  logic          final_res,
    input  logic          dropped,
    output int            fail_count,
    output int            pending
);

    import css_pkg::*;

    typedef struct packed {
        key_t key;
        logic fin;
        logic drop;
    } sorted_t;

    sorted_t sorted_q[$];
    key_t    set_keys[DEPTH];
    int      set_count;
    bit      set_overflow;
    sorted_t want;

    // Swaps a neighbouring pair only when strictly out of order, so equal keys keep their places.
    function automatic bit order_pair(int j);
        key_t t;
        if (set_keys[j-1] > set_keys[j])
        begin
            t = set_keys[j-1];
            set_keys[j-1] = set_keys[j];
            set_keys[j] = t;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void shaker_sort(int n);
        int lo;
        int hi;
        int swap_at;
        int j;
        if (n < 2)
            return;
        lo = 1;
        hi = n - 1;
        swap_at = n - 1;
        while (lo <= hi)
        begin
            for (j = hi; j >= lo; j--)
                if (order_pair(j))
                    swap_at = j;
            lo = swap_at + 1;
            for (j = lo; j <= hi; j++)
                if (order_pair(j))
                    swap_at = j;
            hi = swap_at - 1;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_count    = 0;
            set_overflow = 1'b0;
            sorted_q.delete();
            pending      = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                if (set_count < DEPTH)
                begin
                    set_keys[set_count] = key;
                    set_count++;
                end
                else
                    set_overflow = 1'b1;
                if (last)
                begin
                    shaker_sort(set_count);
                    for (int i = 0; i < set_count; i++)
                        sorted_q.push_back('{key:  set_keys[i],
                                             fin:  (i == set_count - 1),
                                             drop: (i == set_count - 1) && set_overflow});
                    set_count    = 0;
                    set_overflow = 1'b0;
                end
            end
            if (out_valid && !out_stall)
            begin
                if (sorted_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result key=%0d final=%b dropped=%b",
                                 $realtime, sorted_key, final_res, dropped);
                end
                else
                begin
                    want = sorted_q.pop_front();
                    if (sorted_key !== want.key || final_res !== want.fin
                        || dropped !== want.drop)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display(
                                "%0t: expected %0d/%b/%b got %0d/%b/%b (key, final, dropped)",
                                $realtime, want.key, want.fin, want.drop,
                                sorted_key, final_res, dropped);
                    end
                end
            end
            pending = sorted_q.size();
        end
    end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// Testbench top for the cocktail shaker sorter: reset, key sets, stalls and the verdict.
module tb;
    import css_pkg::*;

    localparam int   CLK_PERIOD  = 12;
    localparam int   N_ITEMS     = 320;
    localparam int   QUIET_LIMIT = 20000;
    localparam int   TAIL_CYCLES = 60;
    localparam key_t KEY_MIN     = 32'sh8000_0000;
    localparam key_t KEY_MAX     = 32'sh7fff_ffff;

    typedef enum {PAT_RANDOM, PAT_NARROW, PAT_RISING, PAT_FALLING, PAT_EDGES} pattern_t;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    key_t in_key;
    logic in_last;
    logic out_valid;
    logic out_stall = 1'b0;
    key_t sorted_key;
    logic final_res;
    logic dropped;

    int fail_count;
    int pending;
    int stored_items;
    int quiet_cycles = 0;
    int stall_left = 0;
    bit idle_on = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    cocktail_shaker_sorter uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .key        (in_key),
        .last       (in_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sorted_key (sorted_key),
        .final_res  (final_res),
        .dropped    (dropped)
    );

    css_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .key        (in_key),
        .last       (in_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sorted_key (sorted_key),
        .final_res  (final_res),
        .dropped    (dropped),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Output stalls come in random bursts, which start only while idling is enabled.
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 4);
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("cocktail_shaker_sorter test failed");
                $finish;
            end
        end
    end

    // Called at a falling edge; returns at a falling edge after the transaction is taken.
    // Valid drops after the key marked last, and between keys of one set only for a random gap while idling is enabled.
    task automatic send_key(input key_t k, input logic l);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_key   <= k;
        in_last  <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        if (l)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
    endtask

    task automatic send_set(input int n, input pattern_t pat);
        key_t base;
        key_t k;
        int   stride;
        base   = key_t'($urandom) >>> 2;
        stride = $urandom_range(0, 1000);
        for (int i = 0; i < n; i++)
        begin
            case (pat)
                PAT_NARROW:  k = key_t'($urandom_range(0, 6)) - 3;
                PAT_RISING:  k = base + i * stride;
                PAT_FALLING: k = base - i * stride;
                PAT_EDGES:
                    case ($urandom_range(0, 4))
                        0:       k = KEY_MIN;
                        1:       k = KEY_MAX;
                        2:       k = 0;
                        3:       k = -1;
                        default: k = 1;
                    endcase
                default:     k = key_t'($urandom);
            endcase
            send_key(k, i == n - 1);
        end
        stored_items += (n < DEPTH) ? n : DEPTH;
    endtask

    task automatic wait_drained();
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int n;
        int pick;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_key   = '0;
        in_last  = 1'b0;
        stored_items = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n   = 1'b1;
        idle_on = 1'b1;
        @(negedge clk);

        // Single key, pairs in both orders, extremes with duplicates, reversed and sorted sets.
        send_key(KEY_MIN, 1'b1);
        send_key(KEY_MAX, 1'b0);
        send_key(KEY_MIN, 1'b1);
        send_key(KEY_MIN, 1'b0);
        send_key(KEY_MAX, 1'b1);
        send_key(0, 1'b0);
        send_key(-1, 1'b0);
        send_key(1, 1'b0);
        send_key(KEY_MAX, 1'b0);
        send_key(KEY_MIN, 1'b0);
        send_key(7, 1'b0);
        send_key(7, 1'b0);
        send_key(-7, 1'b0);
        send_key(7, 1'b1);
        send_key(KEY_MAX, 1'b0);
        send_key(1, 1'b0);
        send_key(0, 1'b0);
        send_key(-1, 1'b0);
        send_key(KEY_MIN, 1'b1);
        send_key(-3, 1'b0);
        send_key(-2, 1'b0);
        send_key(0, 1'b0);
        send_key(2, 1'b1);
        stored_items = 23;
        wait_drained();

        // A full store, then one where the key marked last is itself discarded.
        send_set(DEPTH, PAT_FALLING);
        send_set(DEPTH + 1, PAT_RANDOM);

        while (stored_items < N_ITEMS)
        begin
            idle_on = (stored_items < N_ITEMS * 3 / 4) && ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 29);
            if (pick == 0)
                n = DEPTH + $urandom_range(1, 4);
            else if (pick == 1)
                n = $urandom_range(DEPTH - 3, DEPTH);
            else
                n = $urandom_range(1, 12);
            send_set(n, pattern_t'($urandom_range(0, 4)));
            if ($urandom_range(0, 3) == 0)
                wait_drained();
        end

        idle_on = 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("cocktail_shaker_sorter test passed");
        else
            $display("cocktail_shaker_sorter test failed");
        $finish;
    end

endmodule
